// File: design/dmbtb_pkg.sv
// Package for the direct-mapped branch target buffer checker.
// Holds table geometry, branch kind codes, control structs and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmbtb_pkg;

  // Table geometry: the word-aligned PC splits into index and tag.
  // The index width is the floor of log2 of the table size, so only the
  // first power-of-two entries are ever addressed.
  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_BITS      = $clog2(TABLE_ENTRIES + 1) - 1;
  localparam int unsigned TABLE_USED    = 1 << IDX_BITS;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned TAG_BITS      = ADDR_W - 2 - IDX_BITS;
  localparam int unsigned CNT_W         = 32;
  localparam int unsigned KIND_W        = 3;

  // Branch kind codes that take part in checking.
  localparam logic [KIND_W-1:0] KIND_COND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_JUMP = 3'd2;

  // One stored table entry.
  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [ADDR_W-1:0]   target;
  } dmbtb_entry_t;

  localparam int unsigned ENTRY_W = $bits(dmbtb_entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming branch
    logic lookup;   // read the table entry
    logic update;   // score, rewrite, and load the result
  } dmbtb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free; // result register can take a new result
  } dmbtb_sts_t;

  // Saturating increment of a counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/dmbtb_if.sv
// Handshake channel interfaces for the branch input and the scored result.
// Depends on dmbtb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dmbtb_in_if import dmbtb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   pc_address;
  logic [ADDR_W-1:0]   actual_target;
  logic                was_taken;
  logic [KIND_W-1:0]   branch_kind;
  logic                predicted_taken;

  modport source (output valid, pc_address, actual_target, was_taken, branch_kind,
                  predicted_taken, input ready);
  modport sink   (input valid, pc_address, actual_target, was_taken, branch_kind,
                  predicted_taken, output ready);
endinterface

interface dmbtb_out_if import dmbtb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             miss_flag;
  logic             wrong_target_flag;
  logic             wrong_direction_flag;
  logic [CNT_W-1:0] total_branches;
  logic [CNT_W-1:0] total_misses;
  logic [CNT_W-1:0] total_wrong_targets;
  logic [CNT_W-1:0] total_wrong_directions;

  modport source (output valid, miss_flag, wrong_target_flag, wrong_direction_flag,
                  total_branches, total_misses, total_wrong_targets,
                  total_wrong_directions, input ready);
  modport sink   (input valid, miss_flag, wrong_target_flag, wrong_direction_flag,
                  total_branches, total_misses, total_wrong_targets,
                  total_wrong_directions, output ready);
endinterface

`default_nettype wire

// File: design/dmbtb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dmbtb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/dmbtb_ctrl.sv
// Controller of the branch target buffer checker: sequences capture,
// table lookup and update. Depends on dmbtb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmbtb_ctrl import dmbtb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dmbtb_sts_t sts_i,
  output dmbtb_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_READ   = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        // Wait until the result register is free before committing.
        if (sts_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: design/dmbtb_dp.sv
// Datapath of the branch target buffer checker: input latch, table RAM,
// valid bits, scoring, saturating counters and result register.
// Depends on dmbtb_pkg and dmbtb_ram.
`timescale 1ns / 1ps
`default_nettype none

module dmbtb_dp import dmbtb_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dmbtb_cmd_t          cmd_i,
  output dmbtb_sts_t               sts_o,
  input  wire logic [ADDR_W-1:0]   pc_address_i,
  input  wire logic [ADDR_W-1:0]   actual_target_i,
  input  wire logic                was_taken_i,
  input  wire logic [KIND_W-1:0]   branch_kind_i,
  input  wire logic                predicted_taken_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     miss_flag_o,
  output logic                     wrong_target_flag_o,
  output logic                     wrong_direction_flag_o,
  output logic [CNT_W-1:0]         total_branches_o,
  output logic [CNT_W-1:0]         total_misses_o,
  output logic [CNT_W-1:0]         total_wrong_targets_o,
  output logic [CNT_W-1:0]         total_wrong_directions_o
);

  // Latched branch.
  logic [ADDR_W-1:0] pc_q, tgt_q;
  logic              taken_q, pred_q;
  logic [KIND_W-1:0] kind_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pc_q    <= pc_address_i;
      tgt_q   <= actual_target_i;
      taken_q <= was_taken_i;
      kind_q  <= branch_kind_i;
      pred_q  <= predicted_taken_i;
    end
  end

  // Index and tag of the word-aligned PC.
  logic [IDX_BITS-1:0] idx;
  logic [TAG_BITS-1:0] tag;
  assign idx = pc_q[IDX_BITS+1:2];
  assign tag = pc_q[ADDR_W-1:IDX_BITS+2];

  // Table storage for tag and target.
  dmbtb_entry_t rd_entry, wr_entry;
  logic         wr_en;

  assign wr_entry.tag    = tag;
  assign wr_entry.target = tgt_q;

  dmbtb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_USED)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.lookup),
    .raddr_i (idx),
    .rdata_o (rd_entry)
  );

  // Valid bits, cleared at reset.
  logic [TABLE_USED-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[idx] <= 1'b1;
    end
  end

  // Scoring of the branch against the stored entry.
  logic hit_valid, tag_hit, tgt_eq, is_cond, is_jump, checked;
  logic miss, wtgt, wdir, rewrite;

  always_comb begin
    hit_valid = valid_q[idx];
    tag_hit   = (rd_entry.tag == tag);
    tgt_eq    = (rd_entry.target == tgt_q);
    is_cond   = (kind_q == KIND_COND);
    is_jump   = (kind_q == KIND_JUMP);
    checked   = is_jump || (is_cond && taken_q && pred_q);
    miss      = hit_valid && checked && !tag_hit;
    wtgt      = hit_valid && checked && tag_hit && !tgt_eq;
    wdir      = hit_valid && is_cond && tag_hit && tgt_eq && !pred_q && taken_q;
    rewrite   = !hit_valid || is_jump || (is_cond && taken_q);
    wr_en     = cmd_i.update && rewrite;
  end

  // Saturating counters.
  logic [CNT_W-1:0] br_cnt_q, miss_cnt_q, wtgt_cnt_q, wdir_cnt_q;
  logic [CNT_W-1:0] br_cnt_d, miss_cnt_d, wtgt_cnt_d, wdir_cnt_d;

  assign br_cnt_d   = sat_inc(br_cnt_q);
  assign miss_cnt_d = miss ? sat_inc(miss_cnt_q) : miss_cnt_q;
  assign wtgt_cnt_d = wtgt ? sat_inc(wtgt_cnt_q) : wtgt_cnt_q;
  assign wdir_cnt_d = wdir ? sat_inc(wdir_cnt_q) : wdir_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      br_cnt_q   <= '0;
      miss_cnt_q <= '0;
      wtgt_cnt_q <= '0;
      wdir_cnt_q <= '0;
    end else if (cmd_i.update) begin
      br_cnt_q   <= br_cnt_d;
      miss_cnt_q <= miss_cnt_d;
      wtgt_cnt_q <= wtgt_cnt_d;
      wdir_cnt_q <= wdir_cnt_d;
    end
  end

  // Result register; it holds a snapshot until the transfer completes.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      miss_flag_o              <= miss;
      wrong_target_flag_o      <= wtgt;
      wrong_direction_flag_o   <= wdir;
      total_branches_o         <= br_cnt_d;
      total_misses_o           <= miss_cnt_d;
      total_wrong_targets_o    <= wtgt_cnt_d;
      total_wrong_directions_o <= wdir_cnt_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// File: design/direct_mapped_btb_checker.sv
// Direct-mapped branch target buffer checker, top level.
// Branches arrive on branch_i and scored results leave on result_o, both
// valid/ready channels; a transfer happens when valid and ready are high.
// Each branch is looked up in a 256-entry table indexed by PC bits [9:2]
// and tagged by PC bits [31:10]. The result carries the miss, wrong-target
// and wrong-direction flags plus four saturating totals after the update.
// A branch is captured into the input latch, its table entry is read into
// the RAM read register, and the result register is loaded in the update
// step. A new branch is taken only once the last has left the update step,
// as the single table RAM is read, then scored and written back.
// The result sits in its own register, so the next branch is accepted
// while a result still waits; if the receiver stalls longer, the next
// branch holds in the update step and input ready stays low.
// Reset clears the entry valid bits and the counters at once; there is no
// clearing pass, and the block takes a branch right after reset.
// Depends on dmbtb_pkg, dmbtb_if, dmbtb_ctrl and dmbtb_dp.
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_btb_checker import dmbtb_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dmbtb_in_if.sink    branch_i,
  dmbtb_out_if.source result_o
);

  dmbtb_cmd_t cmd;
  dmbtb_sts_t sts;

  // Controller.
  dmbtb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (branch_i.valid),
    .in_ready_o (branch_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  dmbtb_dp u_dp (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cmd_i                    (cmd),
    .sts_o                    (sts),
    .pc_address_i             (branch_i.pc_address),
    .actual_target_i          (branch_i.actual_target),
    .was_taken_i              (branch_i.was_taken),
    .branch_kind_i            (branch_i.branch_kind),
    .predicted_taken_i        (branch_i.predicted_taken),
    .out_valid_o              (result_o.valid),
    .out_ready_i              (result_o.ready),
    .miss_flag_o              (result_o.miss_flag),
    .wrong_target_flag_o      (result_o.wrong_target_flag),
    .wrong_direction_flag_o   (result_o.wrong_direction_flag),
    .total_branches_o         (result_o.total_branches),
    .total_misses_o           (result_o.total_misses),
    .total_wrong_targets_o    (result_o.total_wrong_targets),
    .total_wrong_directions_o (result_o.total_wrong_directions)
  );

endmodule

`default_nettype wire
